@@ rtl/swa_pkg.sv @@
// Shared types, request and action codes, and CRC-8 helpers for the SMBus word sequencer.
// Depends on nothing; used by swa_seq and smbus_word_access_sequencer_core.
package swa_pkg;

	// request codes on req_type
	localparam logic [2:0] REQ_START_READ  = 3'd0;
	localparam logic [2:0] REQ_START_WRITE = 3'd1;
	localparam logic [2:0] REQ_TX_READY    = 3'd2;
	localparam logic [2:0] REQ_RX_BYTE     = 3'd3;
	localparam logic [2:0] REQ_NACK        = 3'd4;
	localparam logic [2:0] REQ_STOP_SEEN   = 3'd5;

	// bus actions
	localparam logic [2:0] ACT_NONE    = 3'd0;
	localparam logic [2:0] ACT_START   = 3'd1;
	localparam logic [2:0] ACT_SEND    = 3'd2;
	localparam logic [2:0] ACT_RESTART = 3'd3;
	localparam logic [2:0] ACT_STOP    = 3'd4;

	// completion status
	localparam logic [1:0] STAT_OK   = 2'd0;
	localparam logic [1:0] STAT_NACK = 2'd1;
	localparam logic [1:0] STAT_PEC  = 2'd2;

	// transfer lengths
	localparam logic [2:0] TX_LEN_WRITE = 3'd4;
	localparam logic [2:0] TX_LEN_READ  = 3'd1;
	localparam logic [1:0] RX_LEN_WRITE = 2'd0;
	localparam logic [1:0] RX_LEN_READ  = 2'd3;

	// configuration
	localparam logic [6:0] DEV_ADDR_RESET = 7'd90;
	localparam logic       REG_DEV_ADDR   = 1'b0;

	// CRC-8
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_MSB  = 8'h80;
	localparam logic [7:0] CRC_INIT = 8'h00;

	typedef logic [7:0] col_t [8];

	typedef struct packed {
		logic [2:0]  req_type;
		logic [7:0]  command;
		logic [15:0] write_word;
		logic [7:0]  received_byte;
	} evt_t;

	typedef struct packed {
		logic [2:0]  bus_action;
		logic [7:0]  send_byte;
		logic        done_res;
		logic [1:0]  status;
		logic [15:0] read_word;
	} res_t;

	function automatic logic [7:0] crc_byte(logic [7:0] crc, logic [7:0] b);
		logic [7:0] c;
		c = crc ^ b;
		for (int i = 0; i < 8; i++) begin
			if ((c & CRC_MSB) != 8'h00)
				c = {c[6:0], 1'b0} ^ CRC_POLY;
			else
				c = {c[6:0], 1'b0};
		end
		return c;
	endfunction

	// Columns of the linear map: one byte followed by n-1 zero bytes.
	// Only ever called on constants, so it folds away at elaboration.
	function automatic col_t span_cols(int unsigned n);
		col_t       cols;
		logic [7:0] c;
		for (int i = 0; i < 8; i++) begin
			c = crc_byte(CRC_INIT, 8'h01 << i);
			for (int unsigned k = 1; k < n; k++)
				c = crc_byte(c, 8'h00);
			cols[i] = c;
		end
		return cols;
	endfunction

	localparam col_t COLS1 = span_cols(1);
	localparam col_t COLS2 = span_cols(2);
	localparam col_t COLS3 = span_cols(3);
	localparam col_t COLS4 = span_cols(4);
	localparam col_t COLS5 = span_cols(5);

	// CRC with zero seed is linear: XOR the columns of the set bits
	function automatic logic [7:0] crc_apply(logic [7:0] b, col_t cols);
		logic [7:0] r;
		r = 8'h00;
		for (int i = 0; i < 8; i++)
			if (b[i])
				r = r ^ cols[i];
		return r;
	endfunction

endpackage

@@ rtl/swa_seq.sv @@
// Transaction state and per-event sequencing for SMBus read-word and write-word.
// Depends on swa_pkg for codes, event and result structs and the CRC helpers.
module swa_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               fire,
	input  swa_pkg::evt_t      evt,
	input  logic [6:0]         device_address,
	output swa_pkg::res_t      res
);

	logic        is_write_q;
	logic        need_restart_q;
	logic        failed_q;
	logic [2:0]  tx_count_q;
	logic [1:0]  rx_count_q;
	logic [7:0]  command_hold_q;
	logic [15:0] word_hold_q;
	logic [7:0]  rx_bytes_q [3];

	logic        is_write_d;
	logic        need_restart_d;
	logic        failed_d;
	logic [2:0]  tx_count_d;
	logic [1:0]  rx_count_d;
	logic [7:0]  command_hold_d;
	logic [15:0] word_hold_d;
	logic        rx_we;

	logic [2:0]  tx_len;
	logic [1:0]  rx_len;
	logic [7:0]  addr_wr;
	logic [7:0]  addr_rd;
	logic [7:0]  write_pec;
	logic [7:0]  read_pec;

	assign tx_len  = is_write_q ? swa_pkg::TX_LEN_WRITE : swa_pkg::TX_LEN_READ;
	assign rx_len  = is_write_q ? swa_pkg::RX_LEN_WRITE : swa_pkg::RX_LEN_READ;
	assign addr_wr = {device_address, 1'b0};
	assign addr_rd = {device_address, 1'b1};

	// PEC frames: addr/W, cmd, lo, hi for a write; addr/W, cmd, addr/R, lo, hi for a read
	assign write_pec = swa_pkg::crc_apply(addr_wr, swa_pkg::COLS4)
		^ swa_pkg::crc_apply(command_hold_q, swa_pkg::COLS3)
		^ swa_pkg::crc_apply(word_hold_q[7:0], swa_pkg::COLS2)
		^ swa_pkg::crc_apply(word_hold_q[15:8], swa_pkg::COLS1);
	assign read_pec = swa_pkg::crc_apply(addr_wr, swa_pkg::COLS5)
		^ swa_pkg::crc_apply(command_hold_q, swa_pkg::COLS4)
		^ swa_pkg::crc_apply(addr_rd, swa_pkg::COLS3)
		^ swa_pkg::crc_apply(rx_bytes_q[0], swa_pkg::COLS2)
		^ swa_pkg::crc_apply(rx_bytes_q[1], swa_pkg::COLS1);

	always_comb begin
		is_write_d     = is_write_q;
		need_restart_d = need_restart_q;
		failed_d       = failed_q;
		tx_count_d     = tx_count_q;
		rx_count_d     = rx_count_q;
		command_hold_d = command_hold_q;
		word_hold_d    = word_hold_q;
		rx_we          = 1'b0;
		res            = '0;
		unique case (evt.req_type)
			swa_pkg::REQ_START_READ, swa_pkg::REQ_START_WRITE: begin
				is_write_d     = (evt.req_type == swa_pkg::REQ_START_WRITE);
				need_restart_d = (evt.req_type == swa_pkg::REQ_START_READ);
				failed_d       = 1'b0;
				tx_count_d     = '0;
				rx_count_d     = '0;
				command_hold_d = evt.command;
				if (evt.req_type == swa_pkg::REQ_START_WRITE)
					word_hold_d = evt.write_word;
				res.bus_action = swa_pkg::ACT_START;
			end
			swa_pkg::REQ_TX_READY: begin
				if (tx_count_q < tx_len) begin
					unique case (tx_count_q)
						3'd0:    res.send_byte = command_hold_q;
						3'd1:    res.send_byte = word_hold_q[7:0];
						3'd2:    res.send_byte = word_hold_q[15:8];
						default: res.send_byte = write_pec;
					endcase
					tx_count_d     = tx_count_q + 3'd1;
					res.bus_action = swa_pkg::ACT_SEND;
				end else if (need_restart_q) begin
					need_restart_d = 1'b0;
					res.bus_action = swa_pkg::ACT_RESTART;
				end else begin
					res.bus_action = swa_pkg::ACT_STOP;
				end
			end
			swa_pkg::REQ_RX_BYTE: begin
				if (rx_count_q < rx_len) begin
					rx_we      = 1'b1;
					rx_count_d = rx_count_q + 2'd1;
				end else begin
					// overflow: drop the byte
					res.bus_action = swa_pkg::ACT_STOP;
				end
			end
			swa_pkg::REQ_NACK: begin
				failed_d       = 1'b1;
				res.bus_action = swa_pkg::ACT_STOP;
			end
			swa_pkg::REQ_STOP_SEEN: begin
				res.done_res = 1'b1;
				if (failed_q)
					res.status = swa_pkg::STAT_NACK;
				else if (!is_write_q && (rx_count_q < swa_pkg::RX_LEN_READ))
					res.status = swa_pkg::STAT_PEC;
				else if (!is_write_q && (rx_bytes_q[2] != read_pec))
					res.status = swa_pkg::STAT_PEC;
				if (!is_write_q && (rx_count_q >= swa_pkg::RX_LEN_READ))
					res.read_word = {rx_bytes_q[1], rx_bytes_q[0]};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			is_write_q     <= 1'b0;
			need_restart_q <= 1'b0;
			failed_q       <= 1'b0;
			tx_count_q     <= '0;
			rx_count_q     <= '0;
			command_hold_q <= '0;
			word_hold_q    <= '0;
		end else if (fire) begin
			is_write_q     <= is_write_d;
			need_restart_q <= need_restart_d;
			failed_q       <= failed_d;
			tx_count_q     <= tx_count_d;
			rx_count_q     <= rx_count_d;
			command_hold_q <= command_hold_d;
			word_hold_q    <= word_hold_d;
		end
	end

	// received bytes hold no reset: each is written before it is read
	always_ff @(posedge clk) begin
		for (int j = 0; j < 3; j++)
			if (fire && rx_we && (rx_count_q == 2'(j)))
				rx_bytes_q[j] <= evt.received_byte;
	end

endmodule

@@ rtl/smbus_word_access_sequencer_core.sv @@
// Top level of the SMBus word sequencer: APB register, input register, result register.
// Depends on swa_pkg and swa_seq.
//
// Use: each bus event enters on the request channel (req_valid / req_stall with
// req_type, command, write_word, received_byte) and yields exactly one result on
// the result channel (res_valid / res_stall with bus_action, send_byte, done_res,
// status, read_word), in order.
// An accepted item loads the input register, and the item then moves on into the result
// register through the sequencing and CRC logic, where res_valid presents its result.
// Throughput is one item per cycle while res_stall is low; the state update in swa_seq,
// including the CRC-8 PEC as a parallel XOR map, sustains that rate.
// When the receiver holds res_stall, the result register holds its item, the input
// register may still take one more item, and req_stall rises once both are full.
// Reset clears the transaction state, empties both registers and sets the device
// address to 90. device_address sits at APB byte address 0; the user must write it only
// while no item is in flight, as the block does not enforce it; pready is always high.
module smbus_word_access_sequencer_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        req_valid,
	output logic        req_stall,
	input  logic [2:0]  req_type,
	input  logic [7:0]  command,
	input  logic [15:0] write_word,
	input  logic [7:0]  received_byte,
	output logic        res_valid,
	input  logic        res_stall,
	output logic [2:0]  bus_action,
	output logic [7:0]  send_byte,
	output logic        done_res,
	output logic [1:0]  status,
	output logic [15:0] read_word
);

	logic [6:0]    dev_addr_q;
	logic          valid_s1;
	swa_pkg::evt_t evt_s1;
	logic          valid_s2;
	swa_pkg::res_t res_s2;
	swa_pkg::res_t res_d;
	logic          take;
	logic          adv;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= swa_pkg::DEV_ADDR_RESET;
		end else if (psel && penable && pwrite && pready
				&& (paddr[2] == swa_pkg::REG_DEV_ADDR)) begin
			dev_addr_q <= pwdata[6:0];
		end
	end

	assign prdata = (paddr[2] == swa_pkg::REG_DEV_ADDR) ? {25'd0, dev_addr_q} : 32'd0;

	// advance the input register whenever the result register is free or drains
	assign adv       = valid_s1 && (!valid_s2 || !res_stall);
	assign req_stall = valid_s1 && !adv;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (adv)
				valid_s1 <= 1'b0;
			if (adv)
				valid_s2 <= 1'b1;
			else if (!res_stall)
				valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			evt_s1 <= '{req_type: req_type, command: command,
				write_word: write_word, received_byte: received_byte};
		if (adv)
			res_s2 <= res_d;
	end

	swa_seq u_seq (
		.clk            (clk),
		.arst_n         (arst_n),
		.fire           (adv),
		.evt            (evt_s1),
		.device_address (dev_addr_q),
		.res            (res_d)
	);

	assign res_valid  = valid_s2;
	assign bus_action = res_s2.bus_action;
	assign send_byte  = res_s2.send_byte;
	assign done_res   = res_s2.done_res;
	assign status     = res_s2.status;
	assign read_word  = res_s2.read_word;

	// an item in the input register reaches the output unless the output is held
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !(valid_s2 && res_stall)) |=> valid_s2)
		else $error("input item did not advance to the result register");

	// stall only with an item waiting behind a held result
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (valid_s1 && valid_s2 && res_stall))
		else $error("request stalled without a held result");

	// a completion report carries no bus action
	a_done_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && done_res) |-> (bus_action == swa_pkg::ACT_NONE))
		else $error("done reported together with a bus action");

	// status and word appear only on completion
	a_status_done: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !done_res) |-> ((status == swa_pkg::STAT_OK) && (read_word == 16'd0)))
		else $error("status or word outside a completion");

	// send_byte is zero unless a byte is sent
	a_send_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && (bus_action != swa_pkg::ACT_SEND)) |-> (send_byte == 8'd0))
		else $error("send_byte set without a send action");

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Testbench for smbus_word_access_sequencer_core: directed and random SMBus word transactions.
// Depends on swa_pkg and the sequencer RTL; predicts every result with a local sequencer model.
module tb;
	import swa_pkg::*;

	localparam int         CYCLE_LIMIT = 300000;
	localparam int         TAIL_CYCLES = 6;
	localparam logic [2:0] REQ_SPARE_A = 3'd6;
	localparam logic [2:0] REQ_SPARE_B = 3'd7;
	localparam logic [2:0] ADDR_DEV    = 3'(4 * REG_DEV_ADDR);

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite, pready;
	logic [2:0]  paddr;
	logic [31:0] pwdata, prdata;
	logic        req_valid, req_stall;
	logic [2:0]  req_type;
	logic [7:0]  command;
	logic [15:0] write_word;
	logic [7:0]  received_byte;
	logic        res_valid, res_stall;
	logic [2:0]  bus_action;
	logic [7:0]  send_byte;
	logic        done_res;
	logic [1:0]  status;
	logic [15:0] read_word;

	// sequencer state as predicted
	logic [6:0]  m_dev_addr;
	logic        m_is_write, m_need_restart, m_failed;
	logic [2:0]  m_tx_count;
	logic [1:0]  m_rx_count;
	logic [7:0]  m_cmd;
	logic [15:0] m_word;
	logic [7:0]  m_rx [3];

	res_t        expected_q [$];
	res_t        oldest;
	int          n_errors, n_sent, n_checked, n_addr_settings;
	int          n_end_ok, n_end_nack, n_end_pec;
	int          cycle_count, stall_left;
	bit          idling, stall_on;

	smbus_word_access_sequencer_core dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.req_valid(req_valid), .req_stall(req_stall), .req_type(req_type),
		.command(command), .write_word(write_word), .received_byte(received_byte),
		.res_valid(res_valid), .res_stall(res_stall), .bus_action(bus_action),
		.send_byte(send_byte), .done_res(done_res), .status(status), .read_word(read_word)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [7:0] crc8_feed(logic [7:0] crc, logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb  = crc[7] ^ b[i];
			crc = {crc[6:0], 1'b0};
			if (fb)
				crc = crc ^ CRC_POLY;
		end
		return crc;
	endfunction

	// frame: addr+W, command, addr+R, low, high
	function automatic logic [7:0] read_frame_pec(logic [6:0] a, logic [7:0] c,
			logic [7:0] lo, logic [7:0] hi);
		logic [7:0] crc;
		crc = crc8_feed(CRC_INIT, {a, 1'b0});
		crc = crc8_feed(crc, c);
		crc = crc8_feed(crc, {a, 1'b1});
		crc = crc8_feed(crc, lo);
		return crc8_feed(crc, hi);
	endfunction

	function automatic res_t sequencer_step(evt_t e);
		res_t       r;
		logic [2:0] tx_len;
		logic [1:0] rx_len;
		logic [7:0] crc;
		r      = '0;
		tx_len = m_is_write ? TX_LEN_WRITE : TX_LEN_READ;
		rx_len = m_is_write ? RX_LEN_WRITE : RX_LEN_READ;
		case (e.req_type)
			REQ_START_READ, REQ_START_WRITE: begin
				m_is_write     = (e.req_type == REQ_START_WRITE);
				m_need_restart = (e.req_type == REQ_START_READ);
				m_failed       = 1'b0;
				m_tx_count     = '0;
				m_rx_count     = '0;
				m_cmd          = e.command;
				if (e.req_type == REQ_START_WRITE)
					m_word = e.write_word;
				r.bus_action = ACT_START;
			end
			REQ_TX_READY: begin
				if (m_tx_count < tx_len) begin
					case (m_tx_count)
						3'd0: r.send_byte = m_cmd;
						3'd1: r.send_byte = m_word[7:0];
						3'd2: r.send_byte = m_word[15:8];
						default: begin
							crc = crc8_feed(CRC_INIT, {m_dev_addr, 1'b0});
							crc = crc8_feed(crc, m_cmd);
							crc = crc8_feed(crc, m_word[7:0]);
							r.send_byte = crc8_feed(crc, m_word[15:8]);
						end
					endcase
					m_tx_count   = m_tx_count + 3'd1;
					r.bus_action = ACT_SEND;
				end else if (m_need_restart) begin
					m_need_restart = 1'b0;
					r.bus_action   = ACT_RESTART;
				end else begin
					r.bus_action = ACT_STOP;
				end
			end
			REQ_RX_BYTE: begin
				if (m_rx_count < rx_len) begin
					m_rx[m_rx_count] = e.received_byte;
					m_rx_count       = m_rx_count + 2'd1;
				end else begin
					r.bus_action = ACT_STOP;
				end
			end
			REQ_NACK: begin
				m_failed     = 1'b1;
				r.bus_action = ACT_STOP;
			end
			REQ_STOP_SEEN: begin
				r.done_res = 1'b1;
				if (m_failed)
					r.status = STAT_NACK;
				else if (!m_is_write && (m_rx_count < RX_LEN_READ ||
						m_rx[2] != read_frame_pec(m_dev_addr, m_cmd, m_rx[0], m_rx[1])))
					r.status = STAT_PEC;
				if (!m_is_write && m_rx_count == RX_LEN_READ)
					r.read_word = {m_rx[1], m_rx[0]};
				case (r.status)
					STAT_OK:   n_end_ok++;
					STAT_NACK: n_end_nack++;
					default:   n_end_pec++;
				endcase
			end
			default: ;
		endcase
		return r;
	endfunction

	// mostly short gaps, a few long ones
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (!idling || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	task automatic pause_sender(input int n);
		if (n > 0) begin
			@(negedge clk);
			req_valid <= 1'b0;
			repeat (n - 1) @(negedge clk);
		end
	endtask

	task automatic send_event(input logic [2:0] t, input logic [7:0] c,
			input logic [15:0] w, input logic [7:0] b);
		evt_t e;
		e = '{req_type: t, command: c, write_word: w, received_byte: b};
		pause_sender(gap_len());
		@(negedge clk);
		req_valid     <= 1'b1;
		req_type      <= t;
		command       <= c;
		write_word    <= w;
		received_byte <= b;
		do
			@(posedge clk);
		while (req_stall);
		expected_q.push_back(sequencer_step(e));
		n_sent++;
	endtask

	task automatic send_rand(input logic [2:0] t);
		send_event(t, 8'($urandom), 16'($urandom), 8'($urandom));
	endtask

	// hold the sender until every outstanding item has its result
	task automatic drain();
		pause_sender(1);
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(input logic wr, input logic [2:0] a, input logic [31:0] d,
			output logic [31:0] q);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= wr;
		paddr   <= a;
		pwdata  <= d;
		@(negedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
		q = prdata;
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic check_address_reg();
		logic [31:0] q;
		apb_access(1'b0, ADDR_DEV, '0, q);
		if (q[6:0] !== m_dev_addr) begin
			$display("%0t ns: device_address read, expected %0h, got %0h",
				$time, m_dev_addr, q[6:0]);
			n_errors++;
		end
	endtask

	task automatic set_device_address(input logic [6:0] a);
		logic [31:0] q;
		apb_access(1'b1, ADDR_DEV, {25'd0, a}, q);
		m_dev_addr = a;
		n_addr_settings++;
		check_address_reg();
	endtask

	task automatic check_field(input string what, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
			n_errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && res_valid && !res_stall) begin
			if (expected_q.size() == 0) begin
				$display("%0t ns: result with nothing expected, bus_action %0h",
					$time, bus_action);
				n_errors++;
			end else begin
				oldest = expected_q.pop_front();
				check_field("bus_action", oldest.bus_action, bus_action);
				check_field("send_byte", oldest.send_byte, send_byte);
				check_field("done_res", oldest.done_res, done_res);
				check_field("status", oldest.status, status);
				check_field("read_word", oldest.read_word, read_word);
				n_checked++;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// receiver back-pressure
	initial begin
		res_stall  = 1'b0;
		stall_left = 0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				res_stall <= 1'b1;
			end else if (stall_on && $urandom_range(0, 3) == 0) begin
				stall_left = $urandom_range(0, 9) == 0 ? $urandom_range(15, 40)
					: $urandom_range(0, 3);
				res_stall <= 1'b1;
			end else begin
				res_stall <= 1'b0;
			end
		end
	end

	task automatic test_address_register();
		check_address_reg();
		set_device_address(7'd0);
		set_device_address(DEV_ADDR_RESET);
	endtask

	// reset state behaves as a read of command 0 with no restart pending
	task automatic test_events_before_start();
		send_event(REQ_TX_READY, 8'hA5, 16'h1234, 8'h00);
		send_event(REQ_TX_READY, 8'h00, 16'h0000, 8'h00);
		send_event(REQ_STOP_SEEN, 8'h00, 16'h0000, 8'h00);
		send_event(REQ_SPARE_A, 8'hFF, 16'hFFFF, 8'hFF);
		send_event(REQ_SPARE_B, 8'h00, 16'h0000, 8'h00);
		drain();
	endtask

	task automatic test_write_word();
		send_event(REQ_START_WRITE, 8'hFF, 16'hFFFF, 8'h00);
		repeat (5) send_event(REQ_TX_READY, 8'h00, 16'h0000, 8'h00);
		send_event(REQ_RX_BYTE, 8'h00, 16'h0000, 8'hFF);
		send_event(REQ_STOP_SEEN, 8'h00, 16'h0000, 8'h00);
		drain();
	endtask

	task automatic test_read_word();
		send_event(REQ_START_READ, 8'h00, 16'hFFFF, 8'h00);
		send_event(REQ_TX_READY, 8'h00, 16'h0000, 8'h00);
		send_event(REQ_TX_READY, 8'h00, 16'h0000, 8'h00);
		send_event(REQ_RX_BYTE, 8'h00, 16'h0000, 8'hFF);
		send_event(REQ_RX_BYTE, 8'h00, 16'h0000, 8'h00);
		send_event(REQ_RX_BYTE, 8'h00, 16'h0000,
			read_frame_pec(m_dev_addr, 8'h00, 8'hFF, 8'h00));
		send_event(REQ_RX_BYTE, 8'h00, 16'h0000, 8'h5A);
		send_event(REQ_STOP_SEEN, 8'h00, 16'h0000, 8'h00);
		send_event(REQ_STOP_SEEN, 8'h00, 16'h0000, 8'h00);
		drain();
	endtask

	task automatic test_nack();
		send_event(REQ_START_READ, 8'h3C, 16'h0000, 8'h00);
		send_event(REQ_NACK, 8'h00, 16'h0000, 8'h00);
		send_event(REQ_STOP_SEEN, 8'h00, 16'h0000, 8'h00);
		drain();
	endtask

	task automatic write_txn();
		int nack_at;
		send_rand(REQ_START_WRITE);
		nack_at = $urandom_range(0, 9) == 0 ? int'($urandom_range(0, 4)) : -1;
		for (int i = 0; i < 5; i++) begin
			if (i == nack_at) begin
				send_rand(REQ_NACK);
				break;
			end
			send_rand(REQ_TX_READY);
		end
		if ($urandom_range(0, 7) == 0)
			send_rand(REQ_RX_BYTE);
		send_rand(REQ_STOP_SEEN);
	endtask

	task automatic read_txn();
		logic [7:0] c, lo, hi, pec;
		int         mode, keep;
		c    = 8'($urandom);
		lo   = 8'($urandom);
		hi   = 8'($urandom);
		mode = $urandom_range(0, 9);
		keep = mode == 1 ? int'($urandom_range(0, 2)) : 3;
		pec  = read_frame_pec(m_dev_addr, c, lo, hi);
		if (mode == 2)
			pec = pec ^ 8'($urandom_range(1, 255));
		send_event(REQ_START_READ, c, 16'($urandom), 8'($urandom));
		send_rand(REQ_TX_READY);
		send_rand(REQ_TX_READY);
		if (mode == 0)
			send_rand(REQ_NACK);
		if (keep > 0) send_event(REQ_RX_BYTE, 8'($urandom), 16'($urandom), lo);
		if (keep > 1) send_event(REQ_RX_BYTE, 8'($urandom), 16'($urandom), hi);
		if (keep > 2) send_event(REQ_RX_BYTE, 8'($urandom), 16'($urandom), pec);
		if ($urandom_range(0, 7) == 0)
			send_rand(REQ_RX_BYTE);
		send_rand(REQ_STOP_SEEN);
		if ($urandom_range(0, 9) == 0)
			send_rand(REQ_STOP_SEEN);
	endtask

	task automatic test_random_phase(input logic [6:0] a, input int n_items, input bit busy);
		int target;
		drain();
		set_device_address(a);
		idling   = busy;
		stall_on = busy;
		target   = n_sent + n_items;
		while (n_sent < target) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: write_txn();
				4, 5, 6, 7: read_txn();
				default: repeat ($urandom_range(1, 6)) send_rand(3'($urandom_range(0, 7)));
			endcase
			if ($urandom_range(0, 29) == 0)
				drain();
		end
	endtask

	initial begin
		arst_n        = 1'b0;
		psel          = 1'b0;
		penable       = 1'b0;
		pwrite        = 1'b0;
		paddr         = '0;
		pwdata        = '0;
		req_valid     = 1'b0;
		req_type      = REQ_START_READ;
		command       = '0;
		write_word    = '0;
		received_byte = '0;
		m_dev_addr     = DEV_ADDR_RESET;
		m_is_write     = 1'b0;
		m_need_restart = 1'b0;
		m_failed       = 1'b0;
		m_tx_count     = '0;
		m_rx_count     = '0;
		m_cmd          = '0;
		m_word         = '0;
		m_rx           = '{default: 8'h00};
		idling         = 1'b1;
		stall_on       = 1'b1;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_address_register();
		test_events_before_start();
		test_write_word();
		test_read_word();
		test_nack();
		test_random_phase(7'd0, 60, 1'b0);
		test_random_phase(7'd127, 120, 1'b1);
		test_random_phase(7'($urandom_range(1, 126)), 110, 1'b1);
		test_random_phase(7'($urandom), 100, 1'b1);
		drain();

		$display("Covered %0d events and %0d checked results over %0d address settings.",
			n_sent, n_checked, n_addr_settings);
		$display("Transactions ended: %0d ok, %0d nack, %0d PEC mismatch.",
			n_end_ok, n_end_nack, n_end_pec);
		if (n_errors == 0 && expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
